### rtl/tfn_pkg.sv
// shared constants of the triangle face normal unit
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

  // default coordinate width (Q16.16)
  localparam int COORD_BITS_DEF = 32;
  // multiplier digit width, one partial product per stage
  localparam int DIG_BITS       = 16;
  // bits of the scaled root floor(sqrt(2^32 * mag^2 / sumsq)), value up to 2^16
  localparam int ROOT_BITS      = 17;
  // target scale: mag^2 * 2^32
  localparam int T_SHIFT        = 32;
  // output component width, signed q1.15
  localparam int NORM_BITS      = 16;
  localparam int Q15_MAX        = 32767;

endpackage
`default_nettype wire

### rtl/tfn_mul.sv
// pipelined unsigned multiplier, one digit of b per stage
`timescale 1ns / 1ps
`default_nettype none
module tfn_mul #(
  parameter int WA  = 32,
  parameter int WB  = 32,
  parameter int DIG = tfn_pkg::DIG_BITS
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);
  import tfn_pkg::*;

  localparam int NS = (WB + DIG - 1) / DIG;
  localparam int BP = NS * DIG;
  localparam int WP = WA + WB;

  logic [BP-1:0] b_ext;
  logic [WA-1:0] a_r   [NS];
  logic [BP-1:0] b_r   [NS];
  logic [WP-1:0] acc_r [NS];

  assign b_ext = BP'(b);

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [WA+DIG-1:0] pp;
    if (i == 0) begin : g_first
      assign pp = (WA+DIG)'(a) * (WA+DIG)'(b_ext[DIG-1:0]);
      always_ff @(posedge clk) begin
        if (en) begin
          acc_r[i] <= WP'(pp);
          a_r[i]   <= a;
          b_r[i]   <= b_ext;
        end
      end
    end else begin : g_next
      assign pp = (WA+DIG)'(a_r[i-1]) * (WA+DIG)'(b_r[i-1][i*DIG +: DIG]);
      always_ff @(posedge clk) begin
        if (en) begin
          acc_r[i] <= acc_r[i-1] + (WP'(pp) << (i*DIG));
          a_r[i]   <= a_r[i-1];
          b_r[i]   <= b_r[i-1];
        end
      end
    end
  end

  assign p = acc_r[NS-1];

endmodule
`default_nettype wire

### rtl/tfn_root.sv
// pipelined digit-by-digit search for floor(sqrt(t / s)), one bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tfn_root #(
  parameter int W = 168
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [W-1:0]                  s,
  input  logic [W-1:0]                  t,
  output logic [tfn_pkg::ROOT_BITS-1:0] m
);
  import tfn_pkg::*;

  // r: t - m^2*s, y: m*s
  logic [W-1:0]           r_r [ROOT_BITS];
  logic [W-1:0]           y_r [ROOT_BITS];
  logic [W-1:0]           s_r [ROOT_BITS];
  logic [ROOT_BITS-1:0]   m_r [ROOT_BITS];

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_step
    localparam int B = ROOT_BITS - 1 - j;
    logic [W-1:0]         r_in;
    logic [W-1:0]         y_in;
    logic [W-1:0]         s_in;
    logic [ROOT_BITS-1:0] m_in;
    logic [W-1:0]         cand;
    logic                 take;

    if (j == 0) begin : g_first
      assign r_in = t;
      assign y_in = '0;
      assign s_in = s;
      assign m_in = '0;
    end else begin : g_next
      assign r_in = r_r[j-1];
      assign y_in = y_r[j-1];
      assign s_in = s_r[j-1];
      assign m_in = m_r[j-1];
    end

    // (m + 2^B)^2 s - m^2 s
    assign cand = (y_in << (B + 1)) + (s_in << (2 * B));
    assign take = (cand <= r_in);

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j] <= take ? (r_in - cand) : r_in;
        y_r[j] <= take ? (y_in + (s_in << B)) : y_in;
        s_r[j] <= s_in;
        m_r[j] <= take ? (m_in | (ROOT_BITS'(1) << B)) : m_in;
      end
    end
  end

  assign m = m_r[ROOT_BITS-1];

endmodule
`default_nettype wire

### rtl/triangle_face_normal_unit.sv
// top level: unit face normal of a triangle, fully pipelined
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | direction | transfer contents
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | tdata: ax ay az bx by bz cx cy cz (COORD_BITS each)
//  out_    | master    | tdata: nx ny nz (16 bits each), tuser: degenerate
//
//  one transfer in per cycle while the output is not stalled, one result per triangle
//  data passes the edge stage, the digit-serial cross multipliers, the cross and
//  magnitude registers, the squaring multipliers, the sum register and the 17-stage root search
//  rst_n (synchronous, active low) clears the valid bits only
//  a stalled output holds the whole pipeline; no item is dropped or repeated
//
module triangle_face_normal_unit #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz from bit 0 up
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // nx, ny, nz from bit 0 up
  output logic [3*tfn_pkg::NORM_BITS-1:0]      out_tdata,
  // degenerate
  output logic [0:0]                           out_tuser
);
  import tfn_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int D    = C + 1;          // vertex difference, signed
  localparam int PW   = 2 * C;          // product magnitude
  localparam int N    = 2 * C + 2;      // cross component, signed
  localparam int MW   = 2 * C + 1;      // cross component magnitude
  localparam int SQW  = 2 * MW;         // square
  localparam int SW   = SQW + 2;        // sum of squares
  localparam int W    = SW + 2 * ROOT_BITS + 2;  // root search width
  localparam int MP1  = (C + DIG_BITS - 1) / DIG_BITS;
  localparam int MP2  = (MW + DIG_BITS - 1) / DIG_BITS;
  localparam int NSTG = 1 + MP1 + 1 + 1 + MP2 + 1 + ROOT_BITS;

  // global advance: the output register is free or being drained
  logic en;
  logic out_valid_r;
  logic [NSTG-1:0] vld_r;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NSTG-2:0], in_tvalid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // stage 1: edge vectors b - a and c - a as sign and magnitude
  logic [C-1:0]        crd  [9];
  logic signed [D-1:0] dif  [6];
  logic [C-1:0]        dm_r [6];
  logic [5:0]          ds_r;

  for (genvar g = 0; g < 9; g++) begin : g_crd
    assign crd[g] = in_tdata[g*C +: C];
  end

  for (genvar i = 0; i < 3; i++) begin : g_dif
    assign dif[i]   = $signed({crd[3+i][C-1], crd[3+i]}) - $signed({crd[i][C-1], crd[i]});
    assign dif[3+i] = $signed({crd[6+i][C-1], crd[6+i]}) - $signed({crd[i][C-1], crd[i]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 6; g++) begin
        dm_r[g] <= dif[g][D-1] ? C'(-dif[g]) : dif[g][C-1:0];
        ds_r[g] <= dif[g][D-1];
      end
    end
  end

  // cross product terms, signs ride alongside the multipliers
  logic [PW-1:0] pp [3];
  logic [PW-1:0] qq [3];
  logic [5:0]    psg;
  logic [5:0]    sg_r [MP1];

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    tfn_mul #(.WA(C), .WB(C), .DIG(DIG_BITS)) u_mul_p (
      .clk(clk), .en(en), .a(dm_r[J]), .b(dm_r[3+K]), .p(pp[i])
    );
    tfn_mul #(.WA(C), .WB(C), .DIG(DIG_BITS)) u_mul_q (
      .clk(clk), .en(en), .a(dm_r[K]), .b(dm_r[3+J]), .p(qq[i])
    );
    assign psg[i]   = ds_r[J] ^ ds_r[3+K];
    assign psg[3+i] = ds_r[K] ^ ds_r[3+J];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_r[0] <= psg;
      for (int i = 1; i < MP1; i++) sg_r[i] <= sg_r[i-1];
    end
  end

  // cross components, two's complement
  logic [N-1:0] pv [3];
  logic [N-1:0] qv [3];
  logic [N-1:0] n_r [3];

  for (genvar i = 0; i < 3; i++) begin : g_ncomp
    assign pv[i] = sg_r[MP1-1][i]   ? (N'(0) - N'(pp[i])) : N'(pp[i]);
    assign qv[i] = sg_r[MP1-1][3+i] ? (N'(0) - N'(qq[i])) : N'(qq[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) n_r[i] <= pv[i] - qv[i];
    end
  end

  // magnitude, sign and zero test
  logic [MW-1:0] nm_r [3];
  logic [2:0]    nsg_r;
  logic          deg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nm_r[i]  <= n_r[i][N-1] ? MW'(N'(0) - n_r[i]) : n_r[i][MW-1:0];
        nsg_r[i] <= n_r[i][N-1];
      end
      deg_r <= (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);
    end
  end

  // squares of the components
  logic [SQW-1:0] sq   [3];
  logic [3:0]     sd_r [MP2];

  for (genvar i = 0; i < 3; i++) begin : g_sq
    tfn_mul #(.WA(MW), .WB(MW), .DIG(DIG_BITS)) u_mul_sq (
      .clk(clk), .en(en), .a(nm_r[i]), .b(nm_r[i]), .p(sq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= {deg_r, nsg_r};
      for (int i = 1; i < MP2; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // sum of squares and per-component targets mag^2 * 2^32
  logic [SW-1:0] s_r;
  logic [W-1:0]  t_r [3];
  logic [3:0]    sd2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      for (int i = 0; i < 3; i++) t_r[i] <= W'(sq[i]) << T_SHIFT;
      sd2_r <= sd_r[MP2-1];
    end
  end

  // root search per component
  logic [ROOT_BITS-1:0] rm [3];
  logic [3:0]           sd3_r [ROOT_BITS];

  for (genvar i = 0; i < 3; i++) begin : g_root
    tfn_root #(.W(W)) u_root (
      .clk(clk), .en(en), .s(W'(s_r)), .t(t_r[i]), .m(rm[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r[0] <= sd2_r;
      for (int i = 1; i < ROOT_BITS; i++) sd3_r[i] <= sd3_r[i-1];
    end
  end

  // round half up via (m + 1) / 2, saturate, apply sign; a degenerate triangle gives zeros
  logic [ROOT_BITS:0]   mp1 [3];
  logic [ROOT_BITS-1:0] rmag [3];
  logic [NORM_BITS-1:0] qmag [3];
  logic [NORM_BITS-1:0] qout [3];
  logic [3*NORM_BITS-1:0] out_tdata_r;
  logic                   out_tuser_r;
  logic                   deg_o;

  assign deg_o = sd3_r[ROOT_BITS-1][3];

  for (genvar i = 0; i < 3; i++) begin : g_out
    assign mp1[i]  = (ROOT_BITS+1)'(rm[i]) + (ROOT_BITS+1)'(1);
    assign rmag[i] = mp1[i][ROOT_BITS:1];
    assign qmag[i] = (rmag[i] > ROOT_BITS'(Q15_MAX)) ? NORM_BITS'(Q15_MAX)
                                                      : NORM_BITS'(rmag[i]);
    assign qout[i] = deg_o ? '0
                   : (sd3_r[ROOT_BITS-1][i] ? (NORM_BITS'(0) - qmag[i]) : qmag[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {qout[2], qout[1], qout[0]};
      out_tuser_r <= deg_o;
    end
  end

  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule
`default_nettype wire

### bench/triangle_face_normal_checker.sv
// checker: watches both channels of the face normal unit, predicts and compares
`timescale 1ns / 1ps
module triangle_face_normal_checker #(
  parameter int COORD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [3*tfn_pkg::NORM_BITS-1:0]      out_tdata,
  input  logic [0:0]                           out_tuser,
  output int                                   fail_count,
  output int                                   pending
);
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  typedef logic signed [255:0] big_t;

  localparam int DUE_DEPTH = 4096;

  // expected results in transfer order, written at wr_idx, read at rd_idx
  normal_t normals_due [DUE_DEPTH];
  int wr_idx = 0;
  int rd_idx = 0;
  int mismatches = 0;

  assign fail_count = mismatches;
  assign pending    = wr_idx - rd_idx;

  // q1.15 code of comp / sqrt(sumsq): largest r with (2r-1)^2 * sumsq <= comp^2 * 2^32
  function automatic logic signed [15:0] unit_code(big_t comp, big_t sumsq);
    big_t mag, target, k, lhs;
    int lo, hi, mid;
    mag = (comp < 0) ? -comp : comp;
    target = (mag * mag) <<< 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 2 * mid - 1;
      lhs = k * k * sumsq;
      if (lhs <= target) lo = mid;
      else hi = mid - 1;
    end
    if (lo > tfn_pkg::Q15_MAX) lo = tfn_pkg::Q15_MAX;
    return 16'((comp < 0) ? -lo : lo);
  endfunction

  function automatic normal_t face_normal(logic [((9*COORD_BITS+7)/8)*8-1:0] tri_bits);
    big_t v[9];
    big_t d1[3], d2[3], n[3], sumsq;
    normal_t r;
    for (int i = 0; i < 9; i++) begin
      v[i] = $signed(tri_bits[i*COORD_BITS +: COORD_BITS]);
    end
    for (int i = 0; i < 3; i++) begin
      d1[i] = v[3+i] - v[i];
      d2[i] = v[6+i] - v[i];
    end
    for (int i = 0; i < 3; i++) begin
      n[i] = d1[(i+1)%3] * d2[(i+2)%3] - d1[(i+2)%3] * d2[(i+1)%3];
    end
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
      return r;
    end
    sumsq = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
    r.nx = unit_code(n[0], sumsq);
    r.ny = unit_code(n[1], sumsq);
    r.nz = unit_code(n[2], sumsq);
    r.degen = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    normal_t want, got;
    if (rst_n && in_tvalid && in_tready) begin
      normals_due[wr_idx % DUE_DEPTH] = face_normal(in_tdata);
      wr_idx++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser[0]};
      if (wr_idx == rd_idx) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %p", got);
      end else begin
        want = normals_due[rd_idx % DUE_DEPTH];
        rd_idx++;
        if (want !== got) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end
endmodule

### bench/triangle_face_normal_unit_tb.sv
// testbench top: stimulus for the face normal unit and the final verdict
`timescale 1ns / 1ps
module triangle_face_normal_unit_tb;
  localparam int CB = tfn_pkg::COORD_BITS_DEF;
  localparam int DW = ((9*CB+7)/8)*8;
  localparam int LATENCY = 29;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [47:0] out_tdata;
  logic [0:0] out_tuser;
  int fail_count, pending;
  int cycles = 0;
  bit hold_sink = 0;  // long receiver stall while the sender keeps offering

  initial begin
    forever #1 clk = ~clk;
  end

  triangle_face_normal_unit dut (.*);

  triangle_face_normal_checker #(.COORD_BITS(CB)) chk (.*);

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall per result, forced low during the long hold
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 4) == 0) gap = 0;
      repeat (gap) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
      while (hold_sink) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
    end
  end

  function automatic logic [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom());
      1: return CB'($signed($urandom_range(0, 2000)) - 1000);
      2: return (CB'($urandom_range(0, 1)) << (CB-1)) - CB'($urandom_range(0, 1));
      default: return CB'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // one triangle transfer, vertices packed ax first; tvalid stays up for a follower
  task automatic send_triangle(logic [CB-1:0] v[9], int gap);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) in_tdata[i*CB +: CB] <= v[i];
    in_tvalid <= 1'b1;
    @(posedge clk iff in_tready);
  endtask

  task automatic send_random(int gap);
    logic [CB-1:0] v[9];
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) v[i] = rand_coord($urandom_range(0, 4) == 0 ? 0 : mode);
    // sometimes a degenerate one: collinear or repeated vertex
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < 3; i++) v[6+i] = v[i];
      1: for (int i = 0; i < 3; i++) v[6+i] = v[3+i] + (v[3+i] - v[i]);
      default: ;
    endcase
    send_triangle(v, gap);
  endtask

  // sender goes idle until every expected result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk iff (pending == 0));
  endtask

  initial begin
    logic [CB-1:0] v[9];
    logic [CB-1:0] maxp, minn;
    int burst_left;
    maxp = {1'b0, {(CB-1){1'b1}}};
    minn = {1'b1, {(CB-1){1'b0}}};
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: axis-aligned unit normals (full-scale component saturates)
    v = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0};
    send_triangle(v, 0);
    v = '{0, 0, 0, 0, 65536, 0, 65536, 0, 0};
    send_triangle(v, 0);
    v = '{0, 0, 0, 0, 0, 65536, 65536, 0, 0};
    send_triangle(v, 1);
    // degenerate: all vertices equal, repeated vertex, collinear
    v = '{5, 6, 7, 5, 6, 7, 5, 6, 7};
    send_triangle(v, 0);
    v = '{1, 2, 3, 9, 9, 9, 1, 2, 3};
    send_triangle(v, 0);
    v = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
    send_triangle(v, 2);
    // diagonal normals, including an equal-weight 45 degree case
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 1};
    send_triangle(v, 0);
    v = '{0, 0, 0, 1, 1, 0, 0, 1, 1};
    send_triangle(v, 0);
    // extremes of every coordinate
    v = '{minn, minn, minn, maxp, minn, minn, minn, maxp, minn};
    send_triangle(v, 0);
    v = '{maxp, maxp, maxp, minn, maxp, maxp, maxp, minn, maxp};
    send_triangle(v, 0);
    v = '{minn, maxp, minn, maxp, minn, maxp, minn, minn, maxp};
    send_triangle(v, 0);
    v = '{maxp, maxp, maxp, minn, minn, minn, 0, maxp, minn};
    send_triangle(v, 0);
    v = '{'1, '1, '1, 0, 0, 0, maxp, 0, minn};
    send_triangle(v, 0);
    // tiny and very lopsided normals
    v = '{0, 0, 0, 1, 0, 0, 0, 1, maxp};
    send_triangle(v, 0);
    v = '{0, 0, 0, maxp, 0, 0, 0, 1, 0};
    send_triangle(v, 3);

    // sender pauses until everything has come back
    wait_drained();

    // random part with a long receiver hold-off partway through
    for (int n = 0; n < 550; n++) begin
      if (n == 200) begin
        hold_sink = 1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_sink = 0;
          end
        join_none
      end
      if (n == 400) wait_drained();
      if (burst_left > 0) begin
        burst_left--;
        send_random(0);
      end else begin
        if ($urandom_range(0, 30) == 0) burst_left = 20;
        send_random(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13));
      end
    end

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### sim.f
rtl/tfn_pkg.sv
rtl/tfn_mul.sv
rtl/tfn_root.sv
rtl/triangle_face_normal_unit.sv
bench/triangle_face_normal_checker.sv
bench/triangle_face_normal_unit_tb.sv
